@@ sv/cffc_pkg.sv @@
// Shared types, constants and helper functions for the float format converter.
// Used by the pipeline stage modules, the top level and the testbench.
// No dependencies.
package cffc_pkg;

   // Register indexes on the configuration port.
   typedef logic [2:0] csr_index_type;
   localparam csr_index_type CSR_EXP_WIDTH  = 3'd0;
   localparam csr_index_type CSR_MANT_WIDTH = 3'd1;
   localparam csr_index_type CSR_EXP_BIAS   = 3'd2;
   localparam csr_index_type CSR_EXPL_LEAD  = 3'd3;
   localparam csr_index_type CSR_BYTE_ORDER = 3'd4;

   // Request functions.
   localparam logic FUNC_DECODE = 1'b0;
   localparam logic FUNC_ENCODE = 1'b1;

   // Value classes carried down the pipeline.
   typedef enum logic [1:0] {
      CLS_NUM,
      CLS_ZERO,
      CLS_INF,
      CLS_NAN
   } class_type;

   // Format settings after clamping, with the byte count of the packed value.
   typedef struct packed {
      logic [3:0]  ew;
      logic [5:0]  mw;
      logic [10:0] bias;
      logic        expl;
      logic        big;
      logic [3:0]  nb;
   } fmt_type;

   // A pair of per-stage control bits (enables or valids) of one module.
   typedef struct packed {
      logic lo;
      logic hi;
   } pair_type;

   // Unpacked operand: class, sign, significand and binary exponent.
   typedef struct packed {
      logic             func;
      logic             sign;
      class_type        cls;
      logic [52:0]      sig;
      logic signed [13:0] exp;
   } item_type;

   // Unpacked operand with the position of its leading one.
   typedef struct packed {
      item_type    item;
      logic [5:0]  lead;
   } lead_item_type;

   // Result before the final byte ordering.
   typedef struct packed {
      logic        func;
      logic [63:0] word;
   } word_type;

   localparam logic [63:0] D64_INF = 64'h7FF0_0000_0000_0000;
   localparam logic [63:0] D64_QNAN = 64'h7FF8_0000_0000_0000;

   // Mask of the n low bits, saturating at 64.
   function automatic logic [63:0] low_mask(input logic [6:0] n);
      logic [63:0] m;
      if (n >= 7'd64) begin
         m = '1;
      end else begin
         m = (64'd1 << n) - 64'd1;
      end
      return m;
   endfunction

   // Reverse the order of the nb low bytes; higher bytes become zero.
   function automatic logic [63:0] byte_swap(input logic [63:0] v, input logic [3:0] nb);
      logic [63:0] r;
      r = '0;
      for (int j = 0; j < 8; j++) begin
         for (int k = 0; k < 8; k++) begin
            if (j < int'(nb) && k == int'(nb) - 1 - j) begin
               r[8*k +: 8] = v[8*j +: 8];
            end
         end
      end
      return r;
   endfunction

   // Position of the most significant set bit (zero for a zero input).
   function automatic logic [5:0] top_bit(input logic [52:0] s);
      logic [5:0] p;
      p = '0;
      for (int i = 0; i < 53; i++) begin
         if (s[i]) begin
            p = 6'(i);
         end
      end
      return p;
   endfunction

endpackage

@@ sv/cffc_if.sv @@
// Request and response channel interfaces of the float format converter.
// Depends on nothing.
interface cffc_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [63:0] operand;

   modport source (output valid, output func, output operand, input ready);
   modport sink (input valid, input func, input operand, output ready);
endinterface

interface cffc_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] result_word;

   modport source (output valid, output result_word, input ready);
   modport sink (input valid, input result_word, output ready);
endinterface

@@ sv/custom_float_format_converter.sv @@
// Converts between a configurable binary float format and IEEE binary64 bit patterns.
// Depends on cffc_pkg, the channel interfaces and the cffc_front, cffc_norm and cffc_back stages.
//
// The converter is a six-stage pipeline: byte ordering, field extraction, leading-one search,
// normalising shift, rounding or packing, and output byte ordering into the response
// register. One request enters every cycle unless the pipeline is stalled. Its response becomes
// valid once the request has passed through every stage register into the response register.
// Each stage holds its item only while the stage after it is full and stalled, so bubbles
// close up and a waiting response does not stop new requests until all six stages are full.
// Format registers are to be written only while no request is in flight; out-of-range widths
// are clamped to the nearest legal value.
module custom_float_format_converter
   import cffc_pkg::*;
#(
   parameter int RAW_WIDTH = 64
)
(
   input  logic          clock,
   input  logic          reset,
   cffc_req_if.sink      req_ch,
   cffc_rsp_if.source    rsp_ch,
   input  logic          csr_we,
   input  csr_index_type csr_index,
   input  logic [10:0]   csr_wdata
);

   localparam int RAW_BYTES = (RAW_WIDTH + 7) / 8;

   logic [3:0]  exp_width_ff;
   logic [5:0]  mant_width_ff;
   logic [10:0] exp_bias_ff;
   logic        expl_lead_ff;
   logic        byte_order_ff;

   fmt_type     fmt;
   logic [63:0] raw_mask;
   pair_type    front_en;
   pair_type    norm_en;
   pair_type    back_en;
   pair_type    front_vld;
   pair_type    norm_vld;
   pair_type    back_vld;
   item_type    front_item;
   item_type    norm_item;

   // Format registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_width_ff  <= 4'd8;
         mant_width_ff <= 6'd23;
         exp_bias_ff   <= 11'd127;
         expl_lead_ff  <= 1'b0;
         byte_order_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_EXP_WIDTH:  exp_width_ff  <= csr_wdata[3:0];
            CSR_MANT_WIDTH: mant_width_ff <= csr_wdata[5:0];
            CSR_EXP_BIAS:   exp_bias_ff   <= csr_wdata;
            CSR_EXPL_LEAD:  expl_lead_ff  <= csr_wdata[0];
            CSR_BYTE_ORDER: byte_order_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Clamped format and the byte count of a packed value.
   always_comb begin
      logic [6:0] total;
      logic [3:0] nb;
      fmt.ew = (exp_width_ff < 4'd2) ? 4'd2 : ((exp_width_ff > 4'd11) ? 4'd11 : exp_width_ff);
      fmt.mw = (mant_width_ff == 6'd0) ? 6'd1
             : ((mant_width_ff > 6'd52) ? 6'd52 : mant_width_ff);
      fmt.bias = exp_bias_ff;
      fmt.expl = expl_lead_ff;
      fmt.big = byte_order_ff;
      total = 7'd1 + 7'(fmt.ew) + 7'(fmt.mw) + 7'd7;
      nb = 4'(total >> 3);
      fmt.nb = (nb > 4'(RAW_BYTES)) ? 4'(RAW_BYTES) : nb;
   end

   // Bits of the raw word that exist.
   always_comb begin
      for (int i = 0; i < 64; i++) begin
         raw_mask[i] = (i < RAW_WIDTH);
      end
   end

   // Each stage loads when it is empty or when the stage after it loads; the last one when its response is taken.
   always_comb begin
      back_en.hi  = !back_vld.hi || rsp_ch.ready;
      back_en.lo  = !back_vld.lo || back_en.hi;
      norm_en.hi  = !norm_vld.hi || back_en.lo;
      norm_en.lo  = !norm_vld.lo || norm_en.hi;
      front_en.hi = !front_vld.hi || norm_en.lo;
      front_en.lo = !front_vld.lo || front_en.hi;
   end

   assign req_ch.ready = front_en.lo;
   assign rsp_ch.valid = back_vld.hi;

   cffc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .fmt        (fmt),
      .raw_mask   (raw_mask),
      .en         (front_en),
      .in_valid   (req_ch.valid),
      .in_func    (req_ch.func),
      .in_operand (req_ch.operand),
      .vld        (front_vld),
      .item       (front_item)
   );

   cffc_norm u_norm (
      .clock    (clock),
      .reset    (reset),
      .en       (norm_en),
      .in_valid (front_vld.hi),
      .in_item  (front_item),
      .vld      (norm_vld),
      .item     (norm_item)
   );

   cffc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .fmt         (fmt),
      .raw_mask    (raw_mask),
      .en          (back_en),
      .in_valid    (norm_vld.hi),
      .in_item     (norm_item),
      .vld         (back_vld),
      .result_word (rsp_ch.result_word)
   );

endmodule

@@ sv/cffc_front.sv @@
// Front stages: byte ordering of the raw word, then field extraction and classification.
// Depends on cffc_pkg.
module cffc_front
   import cffc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  fmt_type     fmt,
   input  logic [63:0] raw_mask,
   input  pair_type    en,
   input  logic        in_valid,
   input  logic        in_func,
   input  logic [63:0] in_operand,
   output pair_type    vld,
   output item_type    item
);

   logic        a_valid_ff;
   logic        a_func_ff;
   logic [63:0] a_word_ff;
   logic [63:0] a_word_in;

   logic        b_valid_ff;
   item_type    b_item_ff;
   item_type    b_item_in;

   // Stage A: bring the raw bytes into natural order; binary64 passes through.
   always_comb begin
      logic [63:0] raw;
      raw = in_operand & raw_mask;
      if (in_func == FUNC_ENCODE) begin
         a_word_in = in_operand;
      end else if (fmt.big) begin
         a_word_in = byte_swap(raw, fmt.nb);
      end else begin
         a_word_in = raw & low_mask({fmt.nb, 3'b000});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en.lo) begin
         a_valid_ff <= in_valid;
      end
      if (en.lo) begin
         a_func_ff <= in_func;
         a_word_ff <= a_word_in;
      end
   end

   // Stage B: split into sign, exponent and significand and classify.
   always_comb begin
      logic [63:0] sh;
      logic [10:0] ex;
      logic [10:0] expmax;
      logic [52:0] mant;
      logic [10:0] dex;
      logic [51:0] frac;
      logic signed [13:0] bias_s;
      logic signed [13:0] mw_s;
      sh = a_word_ff >> (7'(fmt.ew) + 7'(fmt.mw));
      ex = 11'((a_word_ff >> fmt.mw) & low_mask(7'(fmt.ew)));
      expmax = 11'(low_mask(7'(fmt.ew)));
      mant = 53'(a_word_ff & low_mask(7'(fmt.mw)));
      dex = a_word_ff[62:52];
      frac = a_word_ff[51:0];
      bias_s = $signed({3'b000, fmt.bias});
      mw_s = $signed({8'b0, fmt.mw});
      b_item_in.func = a_func_ff;
      b_item_in.sig = '0;
      b_item_in.exp = '0;
      b_item_in.cls = CLS_NUM;
      if (a_func_ff == FUNC_DECODE) begin
         b_item_in.sign = sh[0];
         if (ex == expmax) begin
            b_item_in.cls = (mant == '0) ? CLS_INF : CLS_NAN;
         end else begin
            if (ex == '0) begin
               b_item_in.sig = mant;
               b_item_in.exp = 14'sd1 - bias_s - mw_s;
            end else if (fmt.expl) begin
               b_item_in.sig = mant;
               b_item_in.exp = $signed({3'b000, ex}) - bias_s - mw_s + 14'sd1;
            end else begin
               b_item_in.sig = mant | (53'd1 << fmt.mw);
               b_item_in.exp = $signed({3'b000, ex}) - bias_s - mw_s;
            end
            b_item_in.cls = (b_item_in.sig == '0) ? CLS_ZERO : CLS_NUM;
         end
      end else begin
         b_item_in.sign = a_word_ff[63];
         if (dex == 11'h7FF) begin
            b_item_in.cls = (frac == '0) ? CLS_INF : CLS_NAN;
         end else if (dex == '0 && frac == '0) begin
            b_item_in.cls = CLS_ZERO;
         end else begin
            // Subnormals carry exponent one; the lead count fixes the scale later.
            b_item_in.sig = {dex != '0, frac};
            b_item_in.exp = ((dex == '0) ? 14'sd1 : $signed({3'b000, dex})) - 14'sd1075;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en.hi) begin
         b_valid_ff <= a_valid_ff;
      end
      if (en.hi) begin
         b_item_ff <= b_item_in;
      end
   end

   assign vld.lo = a_valid_ff;
   assign vld.hi = b_valid_ff;
   assign item = b_item_ff;

endmodule

@@ sv/cffc_norm.sv @@
// Normalising stages: leading-one search, then shift of the significand to bit 52.
// Depends on cffc_pkg.
module cffc_norm
   import cffc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  pair_type en,
   input  logic     in_valid,
   input  item_type in_item,
   output pair_type vld,
   output item_type item
);

   logic          c_valid_ff;
   lead_item_type c_item_ff;
   lead_item_type c_item_in;

   logic          d_valid_ff;
   item_type      d_item_ff;
   item_type      d_item_in;

   // Stage C: find the leading one of the significand.
   always_comb begin
      c_item_in.item = in_item;
      c_item_in.lead = top_bit(in_item.sig);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (en.lo) begin
         c_valid_ff <= in_valid;
      end
      if (en.lo) begin
         c_item_ff <= c_item_in;
      end
   end

   // Stage D: move the leading one to bit 52 and fold its position into the exponent.
   always_comb begin
      d_item_in = c_item_ff.item;
      d_item_in.sig = c_item_ff.item.sig << (6'd52 - c_item_ff.lead);
      d_item_in.exp = c_item_ff.item.exp + $signed({8'b0, c_item_ff.lead});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (en.hi) begin
         d_valid_ff <= c_valid_ff;
      end
      if (en.hi) begin
         d_item_ff <= d_item_in;
      end
   end

   assign vld.lo = c_valid_ff;
   assign vld.hi = d_valid_ff;
   assign item = d_item_ff;

endmodule

@@ sv/cffc_back.sv @@
// Back stages: rounding or truncation and packing, then output byte ordering.
// Depends on cffc_pkg.
module cffc_back
   import cffc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  fmt_type     fmt,
   input  logic [63:0] raw_mask,
   input  pair_type    en,
   input  logic        in_valid,
   input  item_type    in_item,
   output pair_type    vld,
   output logic [63:0] result_word
);

   logic        e_valid_ff;
   word_type    e_word_ff;
   word_type    e_word_in;

   logic        f_valid_ff;
   logic [63:0] f_word_ff;
   logic [63:0] f_word_in;

   // Stage E: build the binary64 pattern or the packed custom word.
   always_comb begin
      logic [63:0] sb;
      logic [63:0] sig64;
      logic signed [13:0] be;
      logic signed [13:0] k;
      logic [63:0] q;
      logic [63:0] rem;
      logic [63:0] half;
      logic signed [13:0] st;
      logic signed [13:0] sh;
      logic [10:0] expmax;
      logic [10:0] stored;
      logic [63:0] mant;
      logic [6:0]  mkeep;
      sb = {in_item.sign, 63'b0};
      sig64 = {11'b0, in_item.sig};
      be = in_item.exp + 14'sd1023;
      k = 14'sd1 - be;
      q = sig64 >> k[5:0];
      rem = sig64 & low_mask({1'b0, k[5:0]});
      half = 64'd1 << (k[5:0] - 6'd1);
      st = in_item.exp + $signed({3'b000, fmt.bias});
      sh = 14'sd53 - $signed({8'b0, fmt.mw}) + $signed({13'b0, fmt.expl}) - st;
      expmax = 11'(low_mask(7'(fmt.ew)));
      mkeep = fmt.expl ? 7'(fmt.mw) - 7'd1 : 7'(fmt.mw);
      stored = '0;
      mant = '0;
      e_word_in.func = in_item.func;
      e_word_in.word = '0;
      if (in_item.func == FUNC_DECODE) begin
         case (in_item.cls)
            CLS_ZERO: e_word_in.word = sb;
            CLS_INF:  e_word_in.word = sb | D64_INF;
            CLS_NAN:  e_word_in.word = sb | D64_QNAN;
            CLS_NUM: begin
               if (be >= 14'sd2047) begin
                  e_word_in.word = sb | D64_INF;
               end else if (be >= 14'sd1) begin
                  e_word_in.word = sb | {1'b0, be[10:0], in_item.sig[51:0]};
               end else if (k >= 14'sd54) begin
                  e_word_in.word = sb;
               end else begin
                  // Round to nearest, ties to even.
                  if (rem > half || (rem == half && q[0])) begin
                     q = q + 64'd1;
                  end
                  e_word_in.word = sb | q;
               end
            end
            default: e_word_in.word = sb;
         endcase
      end else begin
         case (in_item.cls)
            CLS_ZERO: begin
               stored = '0;
               mant = '0;
            end
            CLS_INF: begin
               stored = expmax;
               mant = '0;
            end
            CLS_NAN: begin
               stored = expmax;
               mant = 64'd1;
            end
            CLS_NUM: begin
               if (st <= 14'sd0) begin
                  // Too small for a normal: truncated subnormal or zero.
                  stored = '0;
                  mant = (sh >= 14'sd64) ? 64'd0 : (sig64 >> sh[5:0]);
                  mant = mant & low_mask(mkeep);
               end else if (st >= $signed({3'b000, expmax})) begin
                  stored = expmax;
                  mant = '0;
               end else begin
                  stored = st[10:0];
                  if (fmt.expl) begin
                     mant = sig64 >> (6'd53 - fmt.mw);
                  end else begin
                     mant = (sig64 >> (6'd52 - fmt.mw)) & low_mask(7'(fmt.mw));
                  end
               end
            end
            default: begin
               stored = '0;
               mant = '0;
            end
         endcase
         e_word_in.word = ({63'b0, in_item.sign} << (7'(fmt.ew) + 7'(fmt.mw)))
                        | ({53'b0, stored} << fmt.mw) | mant;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (en.lo) begin
         e_valid_ff <= in_valid;
      end
      if (en.lo) begin
         e_word_ff <= e_word_in;
      end
   end

   // Stage F: order the bytes of an encoded word and clear the unused ones.
   always_comb begin
      if (e_word_ff.func == FUNC_ENCODE) begin
         if (fmt.big) begin
            f_word_in = byte_swap(e_word_ff.word, fmt.nb) & raw_mask;
         end else begin
            f_word_in = e_word_ff.word & low_mask({fmt.nb, 3'b000}) & raw_mask;
         end
      end else begin
         f_word_in = e_word_ff.word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (en.hi) begin
         f_valid_ff <= e_valid_ff;
      end
      if (en.hi) begin
         f_word_ff <= f_word_in;
      end
   end

   assign vld.lo = e_valid_ff;
   assign vld.hi = f_valid_ff;
   assign result_word = f_word_ff;

endmodule

@@ tb/sv/tb_custom_float_format_converter.sv @@
// Self-checking testbench for the float format converter: directed and random decode and
// encode requests under several format settings, with random idling on both channels.
// Depends on cffc_pkg, the channel interfaces and the converter top level.
module tb_custom_float_format_converter;
   import cffc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic        func;
      logic [63:0] operand;
   } request_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   csr_index_type csr_index = CSR_EXP_WIDTH;
   logic [10:0] csr_wdata = '0;

   cffc_req_if req_ch ();
   cffc_rsp_if rsp_ch ();

   custom_float_format_converter #(.RAW_WIDTH(64)) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch.sink),
      .rsp_ch   (rsp_ch.source),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Format settings as held by the predictor.
   int unsigned fmt_ew, fmt_mw, fmt_bias, fmt_expl, fmt_big;

   request_type pending_requests[$];
   logic [63:0] expected_words[$];
   int unsigned mismatch_count = 0;
   int unsigned response_count = 0;
   bit idling_on = 1'b1;
   bit hold_requests = 1'b0;
   bit req_taken = 1'b0;
   int unsigned send_gap = 0;
   int unsigned recv_gap = 0;

   always #4 clock = ~clock;

   function automatic logic [63:0] mask_low(input int n);
      if (n <= 0) return 64'd0;
      if (n >= 64) return '1;
      return (64'd1 << n) - 64'd1;
   endfunction

   function automatic int msb_index(input logic [63:0] v);
      int p;
      p = -1;
      for (int i = 0; i < 64; i++) if (v[i]) p = i;
      return p;
   endfunction

   function automatic logic [63:0] reverse_bytes(input logic [63:0] v, input int nb);
      logic [63:0] r;
      r = '0;
      for (int j = 0; j < nb; j++) r[8*(nb-1-j) +: 8] = v[8*j +: 8];
      return r;
   endfunction

   // Round sign * s * 2^e2 to nearest-even binary64.
   function automatic logic [63:0] round_to_double(input logic sgn, input logic [63:0] s,
                                                    input int e2);
      logic [63:0] sb, q, rem, half;
      int p, be, sh, r;
      sb = {sgn, 63'd0};
      if (s == 0) return sb;
      p = msb_index(s);
      be = p + e2 + 1023;
      if (be >= 2047) return sb | D64_INF;
      if (be >= 1) return sb | (64'(be) << 52) | ((s << (52 - p)) & mask_low(52));
      sh = e2 + 1074;
      if (sh >= 0) return sb | (s << sh);
      r = -sh;
      if (r >= 54) return sb;
      q = s >> r;
      rem = s & mask_low(r);
      half = 64'd1 << (r - 1);
      if (rem > half || (rem == half && q[0])) q++;
      return sb | q;
   endfunction

   // Expected result of one conversion under the current format settings.
   function automatic logic [63:0] convert_word(input request_type rq);
      int ew, mw, bias, nb, u, st, sh, p;
      logic [63:0] v, emax, mant, stored, fn, res, frac, dex;
      logic sgn;
      ew = fmt_ew < 2 ? 2 : (fmt_ew > 11 ? 11 : fmt_ew);
      mw = fmt_mw < 1 ? 1 : (fmt_mw > 52 ? 52 : fmt_mw);
      bias = fmt_bias;
      nb = (1 + ew + mw + 7) / 8;
      emax = mask_low(ew);
      if (rq.func == FUNC_DECODE) begin
         v = fmt_big ? reverse_bytes(rq.operand, nb) : rq.operand & mask_low(nb * 8);
         sgn = v[ew + mw];
         stored = (v >> mw) & emax;
         mant = v & mask_low(mw);
         if (stored == 0) res = round_to_double(sgn, mant, 1 - bias - mw);
         else if (stored == emax) res = {sgn, 63'd0} | (mant == 0 ? D64_INF : D64_QNAN);
         else if (fmt_expl) res = round_to_double(sgn, mant, int'(stored) - bias - (mw - 1));
         else res = round_to_double(sgn, mant | (64'd1 << mw), int'(stored) - bias - mw);
         return res;
      end
      sgn = rq.operand[63];
      dex = 64'(rq.operand[62:52]);
      frac = rq.operand & mask_low(52);
      stored = 0;
      mant = 0;
      if (dex == 64'h7FF) begin
         stored = emax;
         mant = frac != 0 ? 64'd1 : 64'd0;
      end else if (!(dex == 0 && frac == 0)) begin
         if (dex == 0) begin
            p = msb_index(frac);
            fn = frac << (52 - p);
            u = p - 1074;
         end else begin
            fn = frac | (64'd1 << 52);
            u = int'(dex) - 1023;
         end
         st = u + bias;
         if (st <= 0) begin
            sh = u - 52 + bias - 1 + mw - (fmt_expl ? 1 : 0);
            if (sh >= 0) mant = fn << sh;
            else if (sh <= -64) mant = 0;
            else mant = fn >> (-sh);
            mant &= mask_low(fmt_expl ? mw - 1 : mw);
         end else if (64'(st) >= emax) begin
            stored = emax;
         end else begin
            stored = 64'(st);
            mant = fmt_expl ? fn >> (53 - mw) : (fn >> (52 - mw)) & mask_low(mw);
         end
      end
      v = (64'(sgn) << (ew + mw)) | (stored << mw) | mant;
      return fmt_big ? reverse_bytes(v, nb) : v & mask_low(nb * 8);
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   // Note whether the presented request was taken at the last rising edge.
   always @(posedge clock) begin
      req_taken <= !reset && req_ch.valid && req_ch.ready;
   end

   // Request driver: presents queued requests with random gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.func <= FUNC_DECODE;
         req_ch.operand <= '0;
      end else if (!req_ch.valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_ch.valid <= 1'b0;
         end else if (pending_requests.size() > 0 && !hold_requests) begin
            req_ch.valid <= 1'b1;
            req_ch.func <= pending_requests[0].func;
            req_ch.operand <= pending_requests[0].operand;
            void'(pending_requests.pop_front());
            if (idling_on && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 8);
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Response ready with random stall bursts.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap <= recv_gap - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
         if (idling_on && $urandom_range(0, 5) == 0) recv_gap <= $urandom_range(1, 8);
      end
   end

   // Monitor: predict on each accepted request, check each accepted response.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            expected_words.push_back(convert_word({req_ch.func, req_ch.operand}));
         if (rsp_ch.valid && rsp_ch.ready) begin
            response_count++;
            if (expected_words.size() == 0)
               report_mismatch("unexpected response", rsp_ch.result_word, '0);
            else begin
               if (rsp_ch.result_word !== expected_words[0])
                  report_mismatch("result_word", rsp_ch.result_word, expected_words[0]);
               void'(expected_words.pop_front());
            end
         end
      end
   end

   task automatic drain();
      wait (pending_requests.size() == 0);
      @(posedge clock);
      while (req_ch.valid || expected_words.size() > 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input int unsigned val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 11'(val);
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_EXP_WIDTH:  fmt_ew = val & 4'hF;
         CSR_MANT_WIDTH: fmt_mw = val & 6'h3F;
         CSR_EXP_BIAS:   fmt_bias = val & 11'h7FF;
         CSR_EXPL_LEAD:  fmt_expl = val & 1;
         CSR_BYTE_ORDER: fmt_big = val & 1;
         default: ;
      endcase
   endtask

   task automatic set_format(input int ew, input int mw, input int bias, input int expl,
                             input int big);
      write_register(CSR_EXP_WIDTH, ew);
      write_register(CSR_MANT_WIDTH, mw);
      write_register(CSR_EXP_BIAS, bias);
      write_register(CSR_EXPL_LEAD, expl);
      write_register(CSR_BYTE_ORDER, big);
   endtask

   function automatic logic [63:0] random_word();
      return {$urandom, $urandom};
   endfunction

   // A binary64 pattern biased towards the interesting exponent ranges.
   function automatic logic [63:0] random_double();
      logic [63:0] d;
      d = random_word();
      case ($urandom_range(0, 5))
         0: d[62:52] = 11'h7FF;
         1: d[62:52] = 11'd0;
         2: d[62:52] = 11'(1023 + $urandom_range(0, 40) - 20);
         3: d[62:52] = 11'(1023 + $urandom_range(0, 2200) - 1100);
         default: ;
      endcase
      if ($urandom_range(0, 9) == 0) d[51:0] = '0;
      return d;
   endfunction

   // A raw pattern of the current format with its exponent often at an edge.
   function automatic logic [63:0] random_raw();
      logic [63:0] v;
      int ew, mw;
      ew = fmt_ew < 2 ? 2 : (fmt_ew > 11 ? 11 : fmt_ew);
      mw = fmt_mw < 1 ? 1 : (fmt_mw > 52 ? 52 : fmt_mw);
      v = random_word();
      case ($urandom_range(0, 4))
         0: v = (v & ~(mask_low(ew) << mw));
         1: v = v | (mask_low(ew) << mw);
         default: ;
      endcase
      if ($urandom_range(0, 9) == 0) v &= ~mask_low(mw);
      return v;
   endfunction

   task automatic queue_random(input int count);
      request_type rq;
      for (int i = 0; i < count; i++) begin
         rq.func = $urandom_range(0, 1) ? FUNC_ENCODE : FUNC_DECODE;
         rq.operand = rq.func == FUNC_ENCODE ? random_double() : random_raw();
         pending_requests.push_back(rq);
      end
   endtask

   // Stimulus sequence.
   initial begin
      logic [63:0] raws[8];
      logic [63:0] dbls[10];
      fmt_ew = 8; fmt_mw = 23; fmt_bias = 127; fmt_expl = 0; fmt_big = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed requests under the default single-precision layout.
      raws = '{64'h0, 64'h8000_0000, 64'h7F80_0000, 64'hFF80_0001,
               64'h0000_0001, 64'h3F80_0000, '1, 64'h7F7F_FFFF};
      dbls = '{64'h0, 64'h8000_0000_0000_0000, D64_INF,
               64'hFFF0_0000_0000_0001, 64'h0000_0000_0000_0001,
               64'h3FF0_0000_0000_0000, 64'h7FEF_FFFF_FFFF_FFFF,
               64'h3800_0000_0000_0000, 64'h36A0_0000_0000_0000, '1};
      foreach (raws[i]) pending_requests.push_back({FUNC_DECODE, raws[i]});
      foreach (dbls[i]) pending_requests.push_back({FUNC_ENCODE, dbls[i]});
      drain();

      // Full pressure point: hold the sender until every response has arrived.
      queue_random(60);
      wait (pending_requests.size() < 30);
      hold_requests = 1'b1;
      wait (expected_words.size() == 0 && !req_ch.valid);
      hold_requests = 1'b0;
      drain();

      // Sweep of format settings, extremes and out-of-range widths included.
      set_format(2, 1, 0, 0, 1);          queue_random(60); drain();
      set_format(11, 52, 1023, 0, 0);     queue_random(80); drain();
      set_format(11, 52, 2047, 1, 1);     queue_random(60); drain();
      set_format(15, 63, 1, 1, 0);        queue_random(60); drain();
      set_format(0, 0, 3, 1, 1);          queue_random(60); drain();
      set_format(5, 10, 15, 0, 1);        queue_random(80); drain();
      set_format(15, 64 - 1, 16383 & 11'h7FF, 1, 1); queue_random(60); drain();
      for (int k = 0; k < 4; k++) begin
         set_format($urandom_range(0, 15), $urandom_range(0, 63), $urandom_range(0, 2047),
                    $urandom_range(0, 1), $urandom_range(0, 1));
         queue_random(50);
         drain();
      end
      // Last part without idling.
      idling_on = 1'b0;
      set_format(8, 23, 127, 0, 0);
      queue_random(60);
      drain();

      $display("Covered %0d responses over decode and encode across format sweeps,",
               response_count);
      $display("including clamped widths, explicit lead and both byte orders.");
      if (mismatch_count == 0 && expected_words.size() == 0) begin
         $display("tb_custom_float_format_converter passed");
      end else begin
         $display("tb_custom_float_format_converter failed");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #5ms;
      $display("tb_custom_float_format_converter failed");
      $finish;
   end

endmodule

@@ filelist.f @@
sv/cffc_pkg.sv
sv/cffc_if.sv
sv/cffc_front.sv
sv/cffc_norm.sv
sv/cffc_back.sv
sv/custom_float_format_converter.sv
tb/sv/tb_custom_float_format_converter.sv
